// ===== hdl/swcd_pkg.sv =====
// Shared types, constants and the CRC-8 byte step for the sensor word deframer.
// Used by every module of the block; depends on nothing else.
package swcd_pkg;

  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  localparam int unsigned POS_W = 3;

  // Byte positions inside a six-byte block.
  localparam logic [POS_W-1:0] POS_HI0  = 3'd0;
  localparam logic [POS_W-1:0] POS_LO0  = 3'd1;
  localparam logic [POS_W-1:0] POS_CRC0 = 3'd2;
  localparam logic [POS_W-1:0] POS_HI1  = 3'd3;
  localparam logic [POS_W-1:0] POS_LO1  = 3'd4;
  localparam logic [POS_W-1:0] POS_CRC1 = 3'd5;

  typedef struct packed {
    logic        frame_ok;
    logic        word_crc_ok;
    logic [1:0]  word_index;
    logic        last_word;
    logic [31:0] word_value;
  } swcd_result_t;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ===== hdl/swcd_frame_core.sv =====
// Frame state and per-byte processing: CRC check per group, word assembly and flags.
// Depends on swcd_pkg for the CRC step, byte positions and the result type.
module swcd_frame_core #(
  parameter int NUM_WORDS = 3
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  byte_adv,
  input  logic [7:0]            data_byte,
  input  logic                  frame_start,
  output logic                  res_valid,
  output swcd_pkg::swcd_result_t res
);
  import swcd_pkg::*;

  localparam int CNT_W = (NUM_WORDS > 4) ? $clog2(NUM_WORDS) : 2;
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(NUM_WORDS - 1);

  logic [POS_W-1:0] pos_r, pos_nxt, pos_cur;
  logic [7:0]       crc_r, crc_nxt, crc_cur;
  logic [31:0]      acc_r, acc_nxt, acc_cur;
  logic             wgood_r, wgood_nxt, wgood_cur;
  logic             fgood_r, fgood_nxt, fgood_cur;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_cur;
  logic             is_last;

  always_comb begin
    pos_cur   = frame_start ? POS_HI0 : pos_r;
    crc_cur   = frame_start ? CRC_INIT : crc_r;
    acc_cur   = frame_start ? 32'd0 : acc_r;
    wgood_cur = frame_start ? 1'b1 : wgood_r;
    fgood_cur = frame_start ? 1'b1 : fgood_r;
    cnt_cur   = frame_start ? '0 : cnt_r;

    crc_nxt   = crc_cur;
    acc_nxt   = acc_cur;
    wgood_nxt = wgood_cur;
    fgood_nxt = fgood_cur;
    case (pos_cur) inside
      POS_HI0, POS_HI1: begin
        crc_nxt = crc8_step(CRC_INIT, data_byte);
        acc_nxt = {acc_cur[23:0], data_byte};
      end
      POS_LO0, POS_LO1: begin
        crc_nxt = crc8_step(crc_cur, data_byte);
        acc_nxt = {acc_cur[23:0], data_byte};
      end
      default: begin
        if (crc_cur != data_byte) begin
          wgood_nxt = 1'b0;
          fgood_nxt = 1'b0;
        end
        crc_nxt = CRC_INIT;
      end
    endcase

    res_valid       = (pos_cur == POS_CRC1);
    is_last         = (cnt_cur >= LAST_CNT);
    res.word_value  = acc_nxt;
    res.word_index  = cnt_cur[1:0];
    res.word_crc_ok = wgood_nxt;
    res.frame_ok    = fgood_nxt;
    res.last_word   = is_last;

    pos_nxt = pos_cur + POS_W'(1);
    cnt_nxt = cnt_cur;
    if (res_valid) begin
      pos_nxt   = POS_HI0;
      acc_nxt   = 32'd0;
      wgood_nxt = 1'b1;
      if (is_last) begin
        crc_nxt   = CRC_INIT;
        fgood_nxt = 1'b1;
        cnt_nxt   = '0;
      end else begin
        cnt_nxt = cnt_cur + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= POS_HI0;
      crc_r   <= CRC_INIT;
      acc_r   <= 32'd0;
      wgood_r <= 1'b1;
      fgood_r <= 1'b1;
      cnt_r   <= '0;
    end else if (byte_adv) begin
      pos_r   <= pos_nxt;
      crc_r   <= crc_nxt;
      acc_r   <= acc_nxt;
      wgood_r <= wgood_nxt;
      fgood_r <= fgood_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_CRC1)
    else $error("byte position left the six-byte block");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= LAST_CNT)
    else $error("word counter passed the last word");

  a_last_restart: assert property (@(posedge clk) disable iff (!rst_n)
    byte_adv && res_valid && is_last |=> cnt_r == '0 && fgood_r && pos_r == POS_HI0)
    else $error("frame state not restarted after the last word");

  a_word_restart: assert property (@(posedge clk) disable iff (!rst_n)
    byte_adv && res_valid |=> pos_r == POS_HI0 && wgood_r)
    else $error("block state not restarted after a word");

endmodule

// ===== hdl/swcd_out_reg.sv =====
// Result register of the deframer, driving the outgoing stream channel.
// Depends on swcd_pkg for the result type.
module swcd_out_reg (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  swcd_pkg::swcd_result_t res,
  output logic                   room,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [31:0]            out_tdata,  // word_value
  output logic [3:0]             out_tuser,  // word_index[1:0], word_crc_ok, frame_ok
  output logic                   out_tlast   // last_word
);
  import swcd_pkg::*;

  logic         valid_r;
  swcd_result_t res_r;

  assign room = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (room) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (room && load) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = res_r.word_value;
  assign out_tuser  = {res_r.frame_ok, res_r.word_crc_ok, res_r.word_index};
  assign out_tlast  = res_r.last_word;

endmodule

// ===== hdl/sensor_word_crc_deframer.sv =====
// Sensor response deframer: checks CRC-8 per 3-byte group and assembles 32-bit words.
// Top level; depends on swcd_pkg, swcd_frame_core and swcd_out_reg.
//
// Usage: bytes arrive on the in_ stream, one request per byte; in_tuser marks the
// first byte of a frame and restarts all frame state before that byte is taken.
// Every sixth byte of a frame completes a word, which leaves on the out_ stream
// with its index, the word CRC flag, the sticky frame CRC flag in tuser and the
// last word of the frame marked by tlast. A consumer drops the frame when the
// frame flag is low on the last word. After the last word the next byte opens a
// new frame even without a start mark.
// Throughput is one byte per cycle unless the receiver stalls: one bitwise CRC step
// and a shift sit between the input register and the result register, which a word
// passes in that order. Synchronous reset empties both registers and returns the
// frame state to the start of a frame. When the receiver stalls, the word waits in
// the result register; bytes that produce no word keep flowing, and input stops
// only when a further word finds the result register still full.
module sensor_word_crc_deframer #(
  parameter int NUM_WORDS = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic [0:0]  in_tuser,   // frame_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // word_value
  output logic [3:0]  out_tuser,  // word_index[1:0], word_crc_ok, frame_ok
  output logic        out_tlast   // last_word
);
  import swcd_pkg::*;

  logic         in_valid_r;
  logic [7:0]   in_byte_r;
  logic         in_start_r;
  logic         byte_adv;
  logic         res_valid;
  logic         room;
  swcd_result_t res;

  assign byte_adv  = in_valid_r && (!res_valid || room);
  assign in_tready = rst_n && (!in_valid_r || byte_adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r  <= in_tdata;
      in_start_r <= in_tuser[0];
    end
  end

  swcd_frame_core #(
    .NUM_WORDS(NUM_WORDS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_adv   (byte_adv),
    .data_byte  (in_byte_r),
    .frame_start(in_start_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  swcd_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (byte_adv && res_valid),
    .res       (res),
    .room      (room),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

endmodule
